FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check, sampled on clk, off during reset
`define CC20_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check, sampled on clk, off during reset
`define CC20_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cc20_pkg.sv
package cc20_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2 = 3'd5;
  localparam logic [2:0] REG_START  = 3'd6;

  // Block constants ("expand 32-byte k")
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce01;
    logic [31:0]      nonce2;
  } cfg_regs_t;

  // Load of the running block counter
  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } ctr_load_t;

  // One classified item between front and back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        message_end;
    logic        new_block;
    logic [5:0]  byte_pos;
    logic [31:0] counter;
    logic [31:0] nonce0;
  } qent_t;

  // Back-end status seen at the top level
  typedef struct packed {
    logic busy;
    logic blk_ready;
    logic pop;
    logic pop_new;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ROUND,
    BK_FINAL
  } bk_state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  // Half a quarter round: first half rotates 16/12, second half 8/7
  function automatic qr_t half_qr(qr_t q, logic second);
    qr_t r;
    logic [31:0] t;
    r   = q;
    r.a = q.a + q.b;
    t   = q.d ^ r.a;
    r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
    r.c = q.c + r.d;
    t   = q.b ^ r.c;
    r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
    return r;
  endfunction

  // Block input state from constants, key, counter and nonce
  function automatic logic [15:0][31:0] block_init(cfg_regs_t c, logic [31:0] ctr,
                                                   logic [31:0] n0);
    logic [15:0][31:0] s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2 * i] = c.key[i][31:0];
      s[5 + 2 * i] = c.key[i][63:32];
    end
    s[12] = ctr;
    s[13] = n0;
    s[14] = c.nonce01[63:32];
    s[15] = c.nonce2;
    return s;
  endfunction

endpackage

FILE: src/cc20_queue.sv
module cc20_queue import cc20_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_item,
  output logic  full,
  input  logic  pop,
  output qent_t head,
  output logic  head_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/cc20_front.sv
module cc20_front import cc20_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      data_valid,
  output logic      data_stall,
  input  in_item_t  data_item,
  input  cfg_regs_t cfg,
  input  ctr_load_t ctr_load,
  output logic      push,
  output qent_t     push_item,
  input  logic      full
);

  logic        in_message;
  logic        in_message_next;
  logic [5:0]  byte_position;
  logic [5:0]  byte_position_next;
  logic [31:0] running_counter;
  logic [31:0] running_counter_next;
  logic [31:0] msg_nonce0;
  logic [31:0] msg_nonce0_next;

  assign data_stall = full;
  assign push       = data_valid && !full;

  // Classify the item and advance message state
  always_comb begin
    logic [5:0]  pos;
    logic [31:0] n0;
    logic [31:0] ctr_inc;
    pos     = in_message ? byte_position : '0;
    n0      = in_message ? msg_nonce0 : cfg.nonce01[31:0];
    ctr_inc = running_counter + 32'd1;

    push_item.data_byte   = data_item.data_byte;
    push_item.message_end = data_item.message_end;
    push_item.new_block   = (pos == '0);
    push_item.byte_pos    = pos;
    push_item.counter     = running_counter;
    push_item.nonce0      = n0;

    in_message_next      = in_message;
    byte_position_next   = byte_position;
    running_counter_next = running_counter;
    msg_nonce0_next      = msg_nonce0;

    if (push) begin
      in_message_next    = !data_item.message_end;
      byte_position_next = data_item.message_end ? '0 : pos + 6'd1;
      msg_nonce0_next    = n0;
      if (pos == '0) begin
        running_counter_next = ctr_inc;
        // counter wrap bumps nonce word 0 for this message only
        if (ctr_inc == '0) begin
          msg_nonce0_next = n0 + 32'd1;
        end
      end
    end
    if (ctr_load.load) begin
      running_counter_next = ctr_load.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message      <= 1'b0;
      byte_position   <= '0;
      running_counter <= '0;
      msg_nonce0      <= '0;
    end else begin
      in_message      <= in_message_next;
      byte_position   <= byte_position_next;
      running_counter <= running_counter_next;
      msg_nonce0      <= msg_nonce0_next;
    end
  end

endmodule

FILE: src/cc20_back.sv
module cc20_back import cc20_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  qent_t      head,
  input  logic       head_valid,
  output logic       pop,
  output logic       result_valid,
  input  logic       result_stall,
  output out_item_t  result_item,
  output bk_status_t status
);

  localparam int STEPS = 4 * DOUBLE_ROUNDS;
  localparam int SW    = $clog2(STEPS);

  bk_state_t         state;
  bk_state_t         state_next;
  logic [SW-1:0]     step;
  logic [15:0][31:0] w;
  logic [15:0][31:0] w_round;
  logic [15:0][31:0] init;
  logic [31:0]       ks [16];
  logic [31:0]       blk_ctr;
  logic [31:0]       blk_n0;
  logic              blk_ready;
  logic              start_blk;
  logic [31:0]       ks_word;

  assign init    = block_init(cfg, blk_ctr, blk_n0);
  assign ks_word = ks[head.byte_pos[5:2]];

  assign status.busy      = (state != BK_IDLE);
  assign status.blk_ready = blk_ready;
  assign status.pop       = pop;
  assign status.pop_new   = pop && head.new_block;

  // Four half quarter rounds in parallel; step[1] picks column or diagonal
  always_comb begin
    logic [3:0] ai, bi, ci, di;
    qr_t        q, r;
    w_round = w;
    for (int j = 0; j < 4; j++) begin
      ai = {2'b00, 2'(j)};
      bi = {2'b01, 2'(j) + {1'b0, step[1]}};
      ci = {2'b10, 2'(j) + {step[1], 1'b0}};
      di = {2'b11, 2'(j) + {step[1], step[1]}};
      q.a = w[ai];
      q.b = w[bi];
      q.c = w[ci];
      q.d = w[di];
      r = half_qr(q, step[0]);
      w_round[ai] = r.a;
      w_round[bi] = r.b;
      w_round[ci] = r.c;
      w_round[di] = r.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: block generation, then byte emission
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start_blk  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head_valid && head.new_block && !blk_ready) begin
          start_blk  = 1'b1;
          state_next = BK_LOAD;
        end else if (head_valid && (!result_valid || !result_stall)) begin
          pop = 1'b1;
        end
      end
      BK_LOAD: begin
        state_next = BK_ROUND;
      end
      BK_ROUND: begin
        if (step == SW'(STEPS - 1)) begin
          state_next = BK_FINAL;
        end
      end
      BK_FINAL: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Block datapath
  always_ff @(posedge clk) begin
    if (start_blk) begin
      blk_ctr <= head.counter;
      blk_n0  <= head.nonce0;
    end
    if (state == BK_LOAD) begin
      w    <= init;
      step <= '0;
    end
    if (state == BK_ROUND) begin
      w    <= w_round;
      step <= step + 1'b1;
    end
    if (state == BK_FINAL) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= w[i] + init[i];
      end
    end
  end

  // Block-ready flag: set when the keystream is stored, used by the first byte
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_ready <= 1'b0;
    end else if (state == BK_FINAL) begin
      blk_ready <= 1'b1;
    end else if (pop && head.new_block) begin
      blk_ready <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_item.out_byte  <= head.data_byte ^ 8'(ks_word >> {head.byte_pos[1:0], 3'b000});
      result_item.last_byte <= head.message_end;
    end
  end

endmodule

FILE: src/chacha20_stream_cipher.sv
// Byte stream cipher, one result item per input item.
// A byte inside a block passes through the queue and the result register; the first byte
// of a block also waits for the shared round unit of four half quarter rounds.
// Throughput: one byte per cycle within a block while result_stall allows; each new block waits for block generation.
// Reset (rst, synchronous): clears control state, counters and config registers;
// the keystream store is not cleared and is always written before it is read.
module chacha20_stream_cipher import cc20_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  in_item_t    data_item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result_item
);

`include "assert_macros.svh"

  cfg_regs_t  cfg;
  ctr_load_t  ctr_load;
  logic       push;
  qent_t      push_item;
  logic       full;
  logic       pop;
  qent_t      head;
  logic       head_valid;
  bk_status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index) inside
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: cfg.key[cfg_index[1:0]] <= cfg_data;
        REG_NONCE01: cfg.nonce01 <= cfg_data;
        REG_NONCE2:  cfg.nonce2  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign ctr_load.load  = cfg_write && (cfg_index == REG_START);
  assign ctr_load.value = cfg_data[31:0];

  cc20_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_item  (data_item),
    .cfg        (cfg),
    .ctr_load   (ctr_load),
    .push       (push),
    .push_item  (push_item),
    .full       (full)
  );

  cc20_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  cc20_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .status       (status)
  );

  // Checks on the front/back split
  `CC20_CHECK(a_no_pop_busy, status.busy, !status.pop, "item taken while block is generated")
  `CC20_CHECK(a_block_first, status.pop_new, status.blk_ready, "first byte used stale keystream")
  `CC20_CHECK(a_pop_has_item, status.pop, head_valid, "pop from empty queue")
  `CC20_CHECK_NEXT(a_pop_result, status.pop, result_valid, "popped item produced no result")

endmodule

FILE: bench/testbench.sv
module testbench import cc20_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DBL_ROUNDS    = 10;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [2:0] REG_BAD = 3'd7;

  // Predicts the cipher output and checks returned bytes in order
  class cipher_scoreboard;
    bit [63:0]  key_word [4];
    bit [63:0]  nonce01;
    bit [31:0]  nonce2;
    bit [31:0]  start_ctr;
    bit [31:0]  ks_word [16];
    bit [31:0]  work [16];
    bit [5:0]   byte_pos;
    bit [31:0]  block_ctr;
    bit [31:0]  msg_nonce0;
    bit         in_msg;
    out_item_t  expected_bytes [$];
    int         errors;
    int         checked;

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    // One 64-byte keystream block from the current settings
    function void make_block();
      bit [31:0] init_word [16];
      init_word[0] = SIGMA0;
      init_word[1] = SIGMA1;
      init_word[2] = SIGMA2;
      init_word[3] = SIGMA3;
      for (int i = 0; i < 4; i++) begin
        init_word[4 + 2 * i] = key_word[i][31:0];
        init_word[5 + 2 * i] = key_word[i][63:32];
      end
      init_word[12] = block_ctr;
      init_word[13] = msg_nonce0;
      init_word[14] = nonce01[63:32];
      init_word[15] = nonce2;
      work = init_word;
      for (int r = 0; r < DBL_ROUNDS; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++)
        ks_word[i] = work[i] + init_word[i];
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[idx[1:0]] = val;
        REG_NONCE01: nonce01 = val;
        REG_NONCE2: nonce2 = val[31:0];
        REG_START: begin
          start_ctr = val[31:0];
          block_ctr = val[31:0];
        end
        default: ;
      endcase
    endfunction

    // Accepted input byte: work out the byte that must come back
    function void accept_byte(in_item_t it);
      bit [31:0] ks;
      out_item_t want;
      if (!in_msg) begin
        msg_nonce0 = nonce01[31:0];
        byte_pos   = '0;
        in_msg     = 1'b1;
      end
      if (byte_pos == 0) begin
        make_block();
        block_ctr++;
        // wrap bumps nonce word 0 for the rest of this message only
        if (block_ctr == 0)
          msg_nonce0++;
      end
      ks = ks_word[byte_pos[5:2]] >> (8 * byte_pos[1:0]);
      want.out_byte  = it.data_byte ^ ks[7:0];
      want.last_byte = it.message_end;
      expected_bytes.push_back(want);
      byte_pos++;
      if (it.message_end) begin
        in_msg   = 1'b0;
        byte_pos = '0;
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result item: byte %02h last %0b",
                   got.out_byte, got.last_byte);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result item %0d: expected byte %02h last %0b, got byte %02h last %0b",
                   checked, want.out_byte, want.last_byte, got.out_byte, got.last_byte);
      end
      checked++;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        data_valid;
  logic        data_stall;
  in_item_t    data_item;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result_item;

  cipher_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  chacha20_stream_cipher #(.DOUBLE_ROUNDS(DBL_ROUNDS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_item    (data_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check accepted items, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_byte(result_item);
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Register write: one cycle of enable, seen by the block at the next edge
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Offer one item, with random idle cycles ahead of it, until accepted
  task automatic send_item(logic [7:0] data, logic last);
    in_item_t it;
    it.data_byte   = data;
    it.message_end = last;
    if ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    data_valid <= 1'b1;
    data_item  <= it;
    do @(posedge clk); while (data_stall);
    sb.accept_byte(it);
  endtask

  // Stop offering and wait for every expected item
  task automatic drain();
    data_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [63:0] pick_setting(int phase);
    if (phase == 1)
      return '1;
    if (phase == 2)
      return '0;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Counter values close to the wrap show up often
  function automatic logic [63:0] pick_counter(int phase);
    if (phase == 1)
      return 64'hFFFF_FFFF;
    if (phase == 2)
      return '0;
    case ($urandom_range(3))
      0: return 64'hFFFF_FFFF - $urandom_range(2);
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly short messages, some around one block, a few around two blocks, rarely up to 300
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return $urandom_range(1, 16);
    if (r < 80)
      return $urandom_range(60, 70);
    if (r < 95)
      return $urandom_range(120, 135);
    return $urandom_range(1, 300);
  endfunction

  initial begin
    int msg_left;
    int sent;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_KEY0;
    cfg_data   <= '0;
    data_valid <= 1'b0;
    data_item  <= '0;
    sb = new;
    msg_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // All-zero settings from reset: raw keystream, then all-ones byte
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    drain();

    // All ones; counter at its top so the first block wraps it
    reg_write(REG_KEY0, '1);
    reg_write(REG_KEY1, '1);
    reg_write(REG_KEY2, '1);
    reg_write(REG_KEY3, '1);
    reg_write(REG_NONCE01, '1);
    reg_write(REG_NONCE2, '1);
    reg_write(REG_START, '1);
    reg_write(REG_BAD, '0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h00, 1'b1);
    // next message starts from the wrapped counter with a fresh nonce word
    send_item(8'hFF, 1'b1);
    drain();

    // Byte-ramp key, counter one
    reg_write(REG_KEY0, 64'h0706_0504_0302_0100);
    reg_write(REG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
    reg_write(REG_KEY2, 64'h1716_1514_1312_1110);
    reg_write(REG_KEY3, 64'h1f1e_1d1c_1b1a_1918);
    reg_write(REG_NONCE01, 64'h4a00_0000_0000_0000);
    reg_write(REG_NONCE2, '0);
    reg_write(REG_START, 64'h1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h0F, 1'b0);
    send_item(8'hF0, 1'b1);
    drain();

    // Random phases; a message may stay open across a settings change
    for (int phase = 0; phase < PHASES; phase++) begin
      reg_write(REG_KEY0, pick_setting(phase));
      reg_write(REG_KEY1, pick_setting(phase));
      reg_write(REG_KEY2, pick_setting(phase));
      reg_write(REG_KEY3, pick_setting(phase));
      reg_write(REG_NONCE01, pick_setting(phase));
      reg_write(REG_NONCE2, pick_setting(phase));
      reg_write(REG_START, pick_counter(phase));
      reg_write(REG_BAD, {$urandom, $urandom});
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // long hold-off on the result side so the input backs up
      if (phase == 0 || phase == 4)
        hold_left = HOLD_CYCLES;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (msg_left == 0)
          msg_left = pick_length();
        send_item(8'($urandom_range(255)), msg_left == 1);
        msg_left--;
        sent++;
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
